FILE: design/fip_pkg.sv
// ----------------------------------------------------------------------------
// fip_pkg
// Types and constants for the binary64 integer power block.
// ----------------------------------------------------------------------------
package fip_pkg;

    // exponent field width of the input item
    localparam int EXP_BITS = 32;
    localparam int IDX_W    = $clog2(EXP_BITS);
    // input tdata width: base, then exponent, padded to whole bytes
    localparam int IN_W     = ((64 + EXP_BITS + 7) / 8) * 8;
    // internal signed exponent width
    localparam int EXP_W    = 13;

    localparam logic [63:0] FP_ONE     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] FP_DEF_NAN = 64'hFFF8_0000_0000_0000;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    // request to the shared float unit
    typedef struct packed {
        logic        start;
        t_op         op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

    // response from the shared float unit
    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_fpu_resp;

endpackage

FILE: design/fip_fpu.sv
// ----------------------------------------------------------------------------
// fip_fpu
// Shared binary64 multiply / divide unit, round to nearest-even, IEEE specials.
// Multiply uses four 27x27 partial products, divide is restoring, one bit a
// cycle. Subnormal inputs and results are shifted one bit a cycle.
// ----------------------------------------------------------------------------
module fip_fpu
    import fip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_fpu_req  i_req,
    output t_fpu_resp o_resp
);

    localparam logic [2:0] U_IDLE   = 3'd0;
    localparam logic [2:0] U_NORMA  = 3'd1;
    localparam logic [2:0] U_NORMB  = 3'd2;
    localparam logic [2:0] U_MUL    = 3'd3;
    localparam logic [2:0] U_DIV    = 3'd4;
    localparam logic [2:0] U_ALIGN  = 3'd5;
    localparam logic [2:0] U_DENORM = 3'd6;
    localparam logic [2:0] U_ROUND  = 3'd7;

    localparam logic [5:0] DIV_LAST = 6'd55;

    logic [2:0]              r_state, n_state;
    t_op                     r_op, n_op;
    logic                    r_sign, n_sign;
    logic [52:0]             r_ma, n_ma, r_mb, n_mb;
    logic signed [EXP_W-1:0] r_ea, n_ea, r_eb, n_eb, r_e, n_e;
    logic [105:0]            r_prod, n_prod;
    logic [53:0]             r_rem, n_rem;
    logic [55:0]             r_q, n_q;
    logic [5:0]              r_cnt, n_cnt;
    logic [1:0]              r_k, n_k;
    logic [54:0]             r_w, n_w;
    logic                    r_done, n_done;
    logic [63:0]             r_res, n_res;

    // operand classification
    logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    always_comb begin
        a_nan  = (&i_req.a[62:52]) && (|i_req.a[51:0]);
        a_inf  = (&i_req.a[62:52]) && !(|i_req.a[51:0]);
        a_zero = (i_req.a[62:0] == 63'd0);
        b_nan  = (&i_req.b[62:52]) && (|i_req.b[51:0]);
        b_inf  = (&i_req.b[62:52]) && !(|i_req.b[51:0]);
        b_zero = (i_req.b[62:0] == 63'd0);
    end

    // partial product selection
    logic [26:0]  pp_x, pp_y;
    logic [53:0]  pp;
    logic [6:0]   pp_sh;
    always_comb begin
        unique case (r_k)
            2'd0: begin pp_x = r_ma[26:0];          pp_y = r_mb[26:0];          pp_sh = 7'd0;  end
            2'd1: begin pp_x = r_ma[26:0];          pp_y = {1'b0, r_mb[52:27]}; pp_sh = 7'd27; end
            2'd2: begin pp_x = {1'b0, r_ma[52:27]}; pp_y = r_mb[26:0];          pp_sh = 7'd27; end
            default: begin
                pp_x = {1'b0, r_ma[52:27]}; pp_y = {1'b0, r_mb[52:27]}; pp_sh = 7'd54;
            end
        endcase
        pp = pp_x * pp_y;
    end

    // divide step
    logic        div_ge;
    logic [53:0] div_sub;
    always_comb begin
        div_ge  = (r_rem >= {1'b0, r_mb});
        div_sub = div_ge ? (r_rem - {1'b0, r_mb}) : r_rem;
    end

    // rounding
    logic                    rnd_inc;
    logic [53:0]             rnd_m;
    logic [52:0]             rnd_m53;
    logic signed [EXP_W-1:0] rnd_e;
    always_comb begin
        rnd_inc = r_w[1] & (r_w[0] | r_w[2]);
        rnd_m   = {1'b0, r_w[54:2]} + {53'd0, rnd_inc};
        if (rnd_m[53]) begin
            rnd_m53 = rnd_m[53:1];
            rnd_e   = r_e + 13'sd1;
        end else begin
            rnd_m53 = rnd_m[52:0];
            rnd_e   = r_e;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_sign  = r_sign;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_ea    = r_ea;
        n_eb    = r_eb;
        n_e     = r_e;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_w     = r_w;
        n_done  = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_op   = i_req.op;
                    n_sign = i_req.a[63] ^ i_req.b[63];
                    n_ma   = {(i_req.a[62:52] != 11'd0), i_req.a[51:0]};
                    n_mb   = {(i_req.b[62:52] != 11'd0), i_req.b[51:0]};
                    n_ea   = (i_req.a[62:52] == 11'd0) ? 13'sd1
                                                       : $signed({2'b00, i_req.a[62:52]});
                    n_eb   = (i_req.b[62:52] == 11'd0) ? 13'sd1
                                                       : $signed({2'b00, i_req.b[62:52]});
                    n_done = 1'b1;
                    // special operands finish at once
                    if (a_nan) begin
                        n_res = i_req.a | 64'h0008_0000_0000_0000;
                    end else if (b_nan) begin
                        n_res = i_req.b | 64'h0008_0000_0000_0000;
                    end else if (i_req.op == OP_MUL) begin
                        if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                            n_res = FP_DEF_NAN;
                        end else if (a_inf || b_inf) begin
                            n_res = {i_req.a[63] ^ i_req.b[63], 11'h7FF, 52'd0};
                        end else if (a_zero || b_zero) begin
                            n_res = {i_req.a[63] ^ i_req.b[63], 63'd0};
                        end else begin
                            n_done  = 1'b0;
                            n_state = U_NORMA;
                        end
                    end else begin
                        if ((a_inf && b_inf) || (a_zero && b_zero)) begin
                            n_res = FP_DEF_NAN;
                        end else if (a_inf || b_zero) begin
                            n_res = {i_req.a[63] ^ i_req.b[63], 11'h7FF, 52'd0};
                        end else if (a_zero || b_inf) begin
                            n_res = {i_req.a[63] ^ i_req.b[63], 63'd0};
                        end else begin
                            n_done  = 1'b0;
                            n_state = U_NORMA;
                        end
                    end
                end
            end
            // bring subnormal significands up to a leading one
            U_NORMA: begin
                if (r_ma[52]) begin
                    n_state = U_NORMB;
                end else begin
                    n_ma = {r_ma[51:0], 1'b0};
                    n_ea = r_ea - 13'sd1;
                end
            end
            U_NORMB: begin
                if (r_mb[52]) begin
                    n_prod = '0;
                    n_k    = 2'd0;
                    n_rem  = {1'b0, r_ma};
                    n_q    = '0;
                    n_cnt  = '0;
                    n_state = (r_op == OP_MUL) ? U_MUL : U_DIV;
                end else begin
                    n_mb = {r_mb[51:0], 1'b0};
                    n_eb = r_eb - 13'sd1;
                end
            end
            // accumulate one partial product a cycle
            U_MUL: begin
                n_prod = r_prod + ({52'd0, pp} << pp_sh);
                n_k    = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = U_ALIGN;
                end
            end
            // one quotient bit a cycle
            U_DIV: begin
                n_q   = {r_q[54:0], div_ge};
                n_rem = {div_sub[52:0], 1'b0};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = U_ALIGN;
                end
            end
            // leading one to the top, keep guard and sticky
            U_ALIGN: begin
                if (r_op == OP_MUL) begin
                    if (r_prod[105]) begin
                        n_w = {r_prod[105:53], r_prod[52], |r_prod[51:0]};
                        n_e = r_ea + r_eb - 13'sd1022;
                    end else begin
                        n_w = {r_prod[104:52], r_prod[51], |r_prod[50:0]};
                        n_e = r_ea + r_eb - 13'sd1023;
                    end
                end else begin
                    if (r_q[55]) begin
                        n_w = {r_q[55:3], r_q[2], (|r_q[1:0]) | (|r_rem)};
                        n_e = r_ea - r_eb + 13'sd1023;
                    end else begin
                        n_w = {r_q[54:2], r_q[1], r_q[0] | (|r_rem)};
                        n_e = r_ea - r_eb + 13'sd1022;
                    end
                end
                n_state = U_DENORM;
            end
            // shift tiny results into the subnormal range
            U_DENORM: begin
                if (r_e < 13'sd1) begin
                    if (r_e < -13'sd60) begin
                        n_w = {54'd0, |r_w};
                        n_e = 13'sd1;
                    end else begin
                        n_w = {1'b0, r_w[54:2], r_w[1] | r_w[0]};
                        n_e = r_e + 13'sd1;
                    end
                end else begin
                    n_state = U_ROUND;
                end
            end
            U_ROUND: begin
                if (rnd_e >= 13'sd2047) begin
                    n_res = {r_sign, 11'h7FF, 52'd0};
                end else begin
                    n_res = {r_sign, rnd_m53[52] ? rnd_e[10:0] : 11'd0, rnd_m53[51:0]};
                end
                n_done  = 1'b1;
                n_state = U_IDLE;
            end
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op   <= n_op;
        r_sign <= n_sign;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_ea   <= n_ea;
        r_eb   <= n_eb;
        r_e    <= n_e;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_k    <= n_k;
        r_w    <= n_w;
        r_res  <= n_res;
    end

    assign o_resp.done   = r_done;
    assign o_resp.result = r_res;

endmodule

FILE: design/float_integer_power_square_multiply_top.sv
// Sequence: accept the item, skip each leading zero of the exponent magnitude,
//   then for each later bit one float square and, for each set bit, one float
//   multiply; a negative exponent adds a reciprocal, then the result is handed on;
//   a subnormal operand or a tiny result adds shift steps in the float unit.
// Throughput: one item at a time; a new item is taken once the result is in the output register.
// Reset: i_rst_n synchronous, active low, clears the sequencers and o_m_tvalid.
// ----------------------------------------------------------------------------
// float_integer_power_square_multiply_top
// Binary64 base raised to a signed integer power by left-to-right
// square-and-multiply on one shared float unit.
// ----------------------------------------------------------------------------
module float_integer_power_square_multiply_top
    import fip_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [IN_W-1:0] i_s_tdata,   // [63:0] base_bits, [64+:EXP_BITS] exponent
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [63:0]     o_m_tdata    // [63:0] result_bits
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_WSQ  = 3'd2;
    localparam logic [2:0] S_WMB  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_WDIV = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(EXP_BITS - 1);

    logic [2:0]          r_state, n_state;
    logic [63:0]         r_base, n_base;
    logic [EXP_BITS-1:0] r_mag, n_mag;
    logic                r_neg, n_neg;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_started, n_started;
    logic [63:0]         r_acc, n_acc;
    logic                r_ovalid, n_ovalid;
    logic [63:0]         r_odata, n_odata;

    logic [EXP_BITS-1:0] in_exp;
    t_fpu_req            req;
    t_fpu_resp           resp;

    fip_fpu u_fpu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_resp (resp)
    );

    assign in_exp     = i_s_tdata[64 +: EXP_BITS];
    assign o_s_tready = (r_state == S_IDLE);

    // exponent bit sequencer
    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_idx     = r_idx;
        n_started = r_started;
        n_acc     = r_acc;
        n_odata   = r_odata;
        n_ovalid  = r_ovalid && !i_m_tready;
        req.start = 1'b0;
        req.op    = OP_MUL;
        req.a     = r_base;
        req.b     = r_acc;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_base    = i_s_tdata[63:0];
                    n_neg     = in_exp[EXP_BITS-1];
                    n_mag     = in_exp[EXP_BITS-1] ? (~in_exp + 1'b1) : in_exp;
                    n_idx     = IDX_TOP;
                    n_started = 1'b0;
                    n_acc     = FP_ONE;
                    n_state   = S_STEP;
                end
            end
            S_STEP: begin
                if (r_started) begin
                    req.start = 1'b1;
                    req.a     = r_acc;
                    n_state   = S_WSQ;
                end else if (r_mag[r_idx]) begin
                    req.start = 1'b1;
                    n_state   = S_WMB;
                end else if (r_idx == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            // square done: multiply by the base where the bit is set
            S_WSQ: begin
                if (resp.done) begin
                    n_acc = resp.result;
                    if (r_mag[r_idx]) begin
                        req.start = 1'b1;
                        req.b     = resp.result;
                        n_state   = S_WMB;
                    end else if (r_idx == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_STEP;
                    end
                end
            end
            S_WMB: begin
                if (resp.done) begin
                    n_acc     = resp.result;
                    n_started = 1'b1;
                    if (r_idx == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_STEP;
                    end
                end
            end
            // reciprocal for a negative exponent
            S_FIN: begin
                if (r_neg) begin
                    req.start = 1'b1;
                    req.op    = OP_DIV;
                    req.a     = FP_ONE;
                    n_state   = S_WDIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WDIV: begin
                if (resp.done) begin
                    n_acc   = resp.result;
                    n_state = S_DONE;
                end
            end
            // hand the item to the output register once it is free
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_acc;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_base    <= n_base;
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_idx     <= n_idx;
        r_started <= n_started;
        r_acc     <= n_acc;
        r_odata   <= n_odata;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule

FILE: design/fip_checker.sv
// ----------------------------------------------------------------------------
// fip_checker
// Port-level checks of the integer power block, bound to the top level.
// ----------------------------------------------------------------------------
module fip_checker
    import fip_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_s_tvalid,
    input logic            o_s_tready,
    input logic            o_m_tvalid,
    input logic            i_m_tready,
    input logic [63:0]     o_m_tdata
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while busy");

    // a new result never appears in the cycle after an accept
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result appeared without work");

    // reset leaves no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind float_integer_power_square_multiply_top fip_checker u_fip_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);

FILE: tb/fip_power_checker.sv
// ----------------------------------------------------------------------------
// fip_power_checker
// Watches both stream channels of the binary64 integer power block, computes
// the expected power of every accepted item and compares each result item
// with the oldest expected value in order.
// ----------------------------------------------------------------------------
module fip_power_checker
    import fip_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_s_tready,
    input  logic [IN_W-1:0] i_s_tdata,   // [63:0] base_bits, [64+:EXP_BITS] exponent
    input  logic            i_m_tvalid,
    input  logic            i_m_tready,
    input  logic [63:0]     i_m_tdata,   // [63:0] result_bits
    output int              o_fail_count,
    output int              o_pending
);

    logic [63:0] expected_powers[$];

    // Left-to-right square-and-multiply on host binary64 (round to nearest-even)
    function automatic logic [63:0] integer_power(logic [63:0] base_bits,
                                                  logic [EXP_BITS-1:0] expo);
        logic [EXP_BITS-1:0] mag;
        logic                neg;
        real                 base_val;
        real                 acc;
        neg      = expo[EXP_BITS-1];
        mag      = neg ? (~expo + 1'b1) : expo;
        base_val = $bitstoreal(base_bits);
        acc      = 1.0;
        for (int i = EXP_BITS - 1; i >= 0; i--) begin
            acc = acc * acc;
            if (mag[i])
                acc = base_val * acc;
        end
        if (!neg)
            return $realtobits(acc);
        // reciprocal of a signed zero is the infinity of the same sign
        if (acc == 0.0)
            return ($realtobits(acc) & 64'h8000_0000_0000_0000) | 64'h7FF0_0000_0000_0000;
        return $realtobits(1.0 / acc);
    endfunction

    function automatic logic is_nan(logic [63:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    endfunction

    assign o_pending = expected_powers.size();

    // Predict on input acceptance, compare on result acceptance
    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_powers.push_back(integer_power(i_s_tdata[63:0],
                                                        i_s_tdata[64 +: EXP_BITS]));
            if (i_m_tvalid && i_m_tready) begin
                if (expected_powers.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, actual %h",
                             $time, i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_powers.pop_front();
                    // any NaN pattern is accepted where a NaN is due
                    if (!(is_nan(want) && is_nan(i_m_tdata)) && want !== i_m_tdata) begin
                        $display("%0t: result_bits mismatch, expected %h, actual %h",
                                 $time, want, i_m_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/float_integer_power_square_multiply_top_tb.sv
// ----------------------------------------------------------------------------
// float_integer_power_square_multiply_top_tb
// Drives directed corner items and random base/exponent pairs into the power
// block with random stalls on both channels; the checker judges the results.
// ----------------------------------------------------------------------------
module float_integer_power_square_multiply_top_tb;
    import fip_pkg::*;

    localparam int  RANDOM_ITEMS = 1650;
    localparam int  CYCLE_LIMIT  = 20_000_000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_s_tvalid;
    logic            o_s_tready;
    logic [IN_W-1:0] i_s_tdata;   // [63:0] base_bits, [64+:EXP_BITS] exponent
    logic            o_m_tvalid;
    logic            i_m_tready;
    logic [63:0]     o_m_tdata;   // [63:0] result_bits
    int              fail_count;
    int              pending;
    int              cycles;
    logic            no_idle;
    int              sink_stall;

    float_integer_power_square_multiply_top dut (.*);

    fip_power_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result sink: stall bursts until the final part of the run
    always @(posedge i_clk) begin
        logic ready_next;
        ready_next = 1'b1;
        if (sink_stall > 0) begin
            ready_next = 1'b0;
            sink_stall <= sink_stall - 1;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            ready_next = 1'b0;
            sink_stall <= $urandom_range(0, 11);
        end
        i_m_tready <= ready_next;
    end

    task automatic send_item(logic [63:0] base_bits, logic [EXP_BITS-1:0] expo);
        if (!no_idle && $urandom_range(0, 2) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {expo, base_bits};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic logic [63:0] pick_base();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: begin
                // close to one in magnitude, so long powers stay finite
                return {1'($urandom), 11'($urandom_range(12'h3F0, 12'h40F)),
                        20'($urandom), 32'($urandom)};
            end
            4, 5, 6: return {$urandom, $urandom};
            7: begin
                // subnormal base
                return {1'($urandom), 11'd0, 20'($urandom), 32'($urandom)};
            end
            8: begin
                case ($urandom_range(0, 5))
                    0: return 64'h0000_0000_0000_0000;
                    1: return 64'h8000_0000_0000_0000;
                    2: return 64'h7FF0_0000_0000_0000;
                    3: return 64'hFFF0_0000_0000_0000;
                    4: return {1'($urandom), 11'h7FF, 20'($urandom) | 20'h1, 32'($urandom)};
                    default: return FP_ONE;
                endcase
            end
            default: return $realtobits(real'($urandom_range(0, 20)) - 10.0);
        endcase
    endfunction

    function automatic logic [EXP_BITS-1:0] pick_exponent();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return EXP_BITS'($urandom_range(0, 80) - 40);
        if (sel < 17)
            return EXP_BITS'($urandom_range(0, 2200) - 1100);
        return EXP_BITS'($urandom);
    endfunction

    initial begin
        logic [63:0] corner_bases[10];
        logic [31:0] corner_exps[8];
        cycles     = 0;
        no_idle    = 1'b0;
        sink_stall = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes and special values
        corner_bases = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                         64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
                         64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                         64'h7FEF_FFFF_FFFF_FFFF, FP_ONE, 64'hC000_0000_0000_0000};
        corner_exps  = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE,
                         32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000};
        for (int i = 0; i < 10; i++)
            send_item(corner_bases[i], corner_exps[i % 8]);
        for (int i = 0; i < 8; i++)
            send_item(corner_bases[(i * 3) % 10], corner_exps[i]);
        send_item(64'h3FF0_0000_0000_0001, 32'h7FFF_FFFF);
        send_item(64'hBFEF_FFFF_FFFF_FFFF, 32'h8000_0000);
        send_item(64'h4000_0000_0000_0000, 32'hFFFF_FBCE);

        // Random part; the last stretch runs without idling
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - 150)
                no_idle = 1'b1;
            send_item(pick_base(), pick_exponent());
        end
        i_s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (5000) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
